// ===== sv/rlesd_pkg.sv =====
// Shared types and constants for the run-length sprite decimating decoder.
// No dependencies; imported by rle_sprite_decimating_decoder_core and rlesd_step.
`timescale 1ns / 1ps

package rlesd_pkg;

   localparam int SPRITE_WIDTH  = 192;
   localparam int SPRITE_HEIGHT = 96;
   localparam int LINE_PIXELS   = 96;
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
   localparam int COLOR_W       = 16;

   typedef struct packed {
      logic       mode;
      logic [7:0] run_length;
      logic [7:0] palette_index;
      logic [15:0] entry_color;
      logic       last_pair;
   } req_type;

   typedef struct packed {
      logic [5:0]  line;
      logic [6:0]  start_column;
      logic [6:0]  pixel_count;
      logic [15:0] pixel_color;
      logic        line_done;
      logic        sprite_done;
   } rsp_type;

   // mode field codes
   localparam logic MODE_PAL_WRITE = 1'b0;
   localparam logic MODE_RUN       = 1'b1;

   typedef struct packed {
      logic [6:0] source_row;
      logic [7:0] source_column;
      logic [6:0] output_column;
      logic       sprite_finished;
   } state_type;

   typedef enum logic [1:0] {
      PH_RUN = 2'b01,
      PH_PAD = 2'b10
   } phase_type;

   typedef struct packed {
      logic      emit;
      rsp_type   rsp;
      state_type next_state;
      phase_type next_phase;
      logic      done;
   } step_type;

endpackage

// ===== sv/rle_sprite_decimating_decoder_core.sv =====
// A run item is accepted into the first stage (item register and palette RAM read); its
// first result is then registered in the response register once the output is free. One
// item per cycle while results are not stalled and each item needs a single step; a run
// that ends an even row without filling the line adds a padding step, and a last pair
// adds one for each source row still to close, odd rows included. A stalled result holds
// the step, and so the input, until it is taken. Palette writes complete in the accept
// cycle; the palette RAM read sets the first stage. Reset (synchronous, active high)
// clears row/column state, background color and the pipeline; palette contents are not cleared.
// Top level; depends on rlesd_pkg, rlesd_ram and rlesd_step.
`timescale 1ns / 1ps

module rle_sprite_decimating_decoder_core import rlesd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [COLOR_W-1:0] csr_wr_data
);

   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_item_ff;
   phase_type          phase_ff, phase_in;
   state_type          st_ff, st_in;
   logic [COLOR_W-1:0] bg_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic               req_accept;
   logic               out_free;
   logic               step_go;
   logic               pal_wr_en;
   logic               pal_rd_en;
   logic [COLOR_W-1:0] pal_data;
   step_type           step;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step_go    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !(step_go && step.done);
   assign req_accept = req_valid && !req_stall;
   assign pal_wr_en  = req_accept && (req_data.mode == MODE_PAL_WRITE) &&
                       ({1'b0, req_data.palette_index} < 9'(PALETTE_DEPTH));
   assign pal_rd_en  = req_accept && (req_data.mode == MODE_RUN);

   rlesd_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_data.palette_index[PAL_ADDR_W-1:0]),
      .wr_data (req_data.entry_color),
      .rd_en   (pal_rd_en),
      .rd_addr (req_data.palette_index[PAL_ADDR_W-1:0]),
      .rd_data (pal_data)
   );

   rlesd_step u_step (
      .phase    (phase_ff),
      .st       (st_ff),
      .item     (s1_item_ff),
      .pal_data (pal_data),
      .bg_color (bg_ff),
      .step     (step)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pal_rd_en) begin
         s1_valid_in = 1'b1;
      end else if (step_go && step.done) begin
         s1_valid_in = 1'b0;
      end
      phase_in     = step_go ? step.next_phase : phase_ff;
      st_in        = step_go ? step.next_state : st_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step_go && step.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PH_RUN;
         st_ff        <= '0;
         bg_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pal_rd_en) begin
         s1_item_ff <= req_data;
      end
      if (step_go && step.emit) begin
         rsp_data_ff <= step.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/rlesd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rlesd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rlesd_step.sv =====
// One decode step: either the run part of a pair or one end-of-row padding pass.
// Depends on rlesd_pkg.
`timescale 1ns / 1ps

module rlesd_step import rlesd_pkg::*; (
   input  phase_type         phase,
   input  state_type         st,
   input  req_type           item,
   input  logic [COLOR_W-1:0] pal_data,
   input  logic [COLOR_W-1:0] bg_color,
   output step_type          step
);

   logic [8:0] sum;
   logic [8:0] run_end;
   logic [8:0] end_p1;
   logic [8:0] col_p1;
   logic [7:0] span;
   logic [7:0] room;
   logic [7:0] n_out;
   logic [6:0] ocol_next;
   logic [7:0] scol_next;
   logic [7:0] row_p1;
   logic [7:0] row_p2;
   logic       advance;
   logic       even;
   logic       row_end;
   logic       merge;
   logic       last_line;
   logic [COLOR_W-1:0] color;

   always_comb begin
      sum       = {1'b0, st.source_column} + {1'b0, item.run_length};
      run_end   = (sum > 9'(SPRITE_WIDTH)) ? 9'(SPRITE_WIDTH) : sum;
      advance   = run_end > {1'b0, st.source_column};
      even      = !st.source_row[0];
      // kept columns in [col, end) are the even ones
      end_p1    = run_end + 9'd1;
      col_p1    = {1'b0, st.source_column} + 9'd1;
      span      = end_p1[8:1] - col_p1[8:1];
      room      = (st.output_column < 7'(LINE_PIXELS)) ?
                  8'(LINE_PIXELS) - {1'b0, st.output_column} : 8'd0;
      n_out     = (even && advance) ? ((span > room) ? room : span) : 8'd0;
      ocol_next = 7'({1'b0, st.output_column} + n_out);
      scol_next = advance ? run_end[7:0] : st.source_column;
      row_end   = scol_next >= 8'(SPRITE_WIDTH);
      merge     = row_end && (n_out != 8'd0) && (ocol_next >= 7'(LINE_PIXELS));
      row_p1    = {1'b0, st.source_row} + 8'd1;
      row_p2    = {1'b0, st.source_row} + 8'd2;
      last_line = row_p2 >= 8'(SPRITE_HEIGHT);
      color     = (item.palette_index == 8'd0 ||
                   {1'b0, item.palette_index} >= 9'(PALETTE_DEPTH)) ? bg_color : pal_data;

      step            = '0;
      step.next_state = st;
      step.next_phase = PH_RUN;
      step.done       = 1'b1;

      case (phase)
         PH_RUN: begin
            if (!st.sprite_finished) begin
               step.emit                         = n_out != 8'd0;
               step.rsp.line                     = st.source_row[6:1];
               step.rsp.start_column             = st.output_column;
               step.rsp.pixel_count              = n_out[6:0];
               step.rsp.pixel_color              = color;
               step.rsp.line_done                = merge;
               step.rsp.sprite_done              = merge && last_line;
               step.next_state.source_column     = scol_next;
               step.next_state.output_column     = ocol_next;
               if (row_end && (merge || !even)) begin
                  // row closes here: no padding item needed
                  step.next_state.source_row      = row_p1[6:0];
                  step.next_state.source_column   = '0;
                  step.next_state.output_column   = '0;
                  step.next_state.sprite_finished = (merge && last_line) ||
                                                    (row_p1 >= 8'(SPRITE_HEIGHT));
                  if (item.last_pair && !step.next_state.sprite_finished) begin
                     step.done       = 1'b0;
                     step.next_phase = PH_PAD;
                  end
               end else if (row_end || item.last_pair) begin
                  step.done       = 1'b0;
                  step.next_phase = PH_PAD;
               end
            end
         end
         PH_PAD: begin
            step.emit                       = even;
            step.rsp.line                   = st.source_row[6:1];
            step.rsp.start_column           = st.output_column;
            step.rsp.pixel_count            = room[6:0];
            step.rsp.pixel_color            = bg_color;
            step.rsp.line_done              = 1'b1;
            step.rsp.sprite_done            = last_line;
            step.next_state.source_row      = row_p1[6:0];
            step.next_state.source_column   = '0;
            step.next_state.output_column   = '0;
            step.next_state.sprite_finished = (even && last_line) ||
                                              (row_p1 >= 8'(SPRITE_HEIGHT));
            if (item.last_pair && !step.next_state.sprite_finished) begin
               step.done       = 1'b0;
               step.next_phase = PH_PAD;
            end
         end
         default: begin
            step.done = 1'b1;
         end
      endcase
   end

endmodule
